// File: hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps
package kts_pkg;

    // Widths of byte offsets and of the line counter.
    localparam int POS_BITS  = 24;
    localparam int LINE_BITS = 20;

    typedef enum logic [2:0] {
        M_IDLE     = 3'd0,
        M_SLASH    = 3'd1,
        M_COMMENT  = 3'd2,
        M_STRING   = 3'd3,
        M_NUMBER   = 3'd4,
        M_NUMDOT   = 3'd5,
        M_FRACTION = 3'd6,
        M_IDENT    = 3'd7
    } t_mode;

    localparam logic [4:0] K_LBRACE   = 5'd0;
    localparam logic [4:0] K_RBRACE   = 5'd1;
    localparam logic [4:0] K_COMMA    = 5'd2;
    localparam logic [4:0] K_DOT      = 5'd3;
    localparam logic [4:0] K_SLASH    = 5'd4;
    localparam logic [4:0] K_SEMI     = 5'd5;
    localparam logic [4:0] K_STRING   = 5'd6;
    localparam logic [4:0] K_NUMBER   = 5'd7;
    localparam logic [4:0] K_IDENT    = 5'd8;
    localparam logic [4:0] K_KEYWORD0 = 5'd9;
    localparam logic [4:0] K_END      = 5'd19;
    localparam logic [4:0] K_BAD      = 5'd20;
    localparam logic [4:0] K_UNTERM   = 5'd21;

    localparam int NUM_KW = 10;

    // Keyword text, one byte per character position (zero past the end).
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"p", "l", "a", "y", 8'h0, 8'h0, 8'h0, 8'h0},
        '{"i", "m", "p", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"a", "s", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"c", "p", "m", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"p", "a", "t", "t", "e", "r", "n", 8'h0},
        '{"s", "e", "t", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
        '{"s", "a", "m", "p", "l", "e", 8'h0, 8'h0},
        '{"v", "o", "l", "u", "m", "e", 8'h0, 8'h0},
        '{"p", "i", "t", "c", "h", 8'h0, 8'h0, 8'h0},
        '{"l", "o", "o", "p", 8'h0, 8'h0, 8'h0, 8'h0}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd4, 4'd3, 4'd2, 4'd3, 4'd7, 4'd3, 4'd6, 4'd6, 4'd5, 4'd4
    };

    // One token request as it leaves the front end, before position widths apply.
    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] bad_char;
        logic       last;
    } t_tok_ctl;

endpackage

// File: hw/rtl/kts_front.sv
`timescale 1ns / 1ps
module kts_front
    import kts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [19:0]          i_cfg_data,
    input  logic                 i_take,
    input  logic [7:0]           i_ch,
    input  logic                 i_char_valid,
    input  logic                 i_eos,
    output logic [2:0]           o_cnt,
    output t_tok_ctl             o_ctl   [4],
    output logic [POS_BITS-1:0]  o_start [4],
    output logic [POS_BITS-1:0]  o_len   [4],
    output logic [LINE_BITS-1:0] o_line  [4]
);

    localparam logic [POS_BITS-1:0]  PMAX = '1;
    localparam logic [LINE_BITS-1:0] LMAX = '1;

    t_mode                r_mode, n_mode;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_tstart, n_tstart;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic [LINE_BITS-1:0] r_first;
    logic [NUM_KW-1:0]    r_cand, n_cand;
    logic [3:0]           r_ilen, n_ilen;

    logic [POS_BITS-1:0] pos, pos1, ts1, pm1;
    logic [7:0] c;
    logic is_dig, is_let;
    logic [NUM_KW-1:0] kw_keep;
    logic [4:0] id_kind;

    function automatic logic [POS_BITS-1:0] sub0(input logic [POS_BITS-1:0] a,
                                                 input logic [POS_BITS-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [POS_BITS-1:0] inc(input logic [POS_BITS-1:0] a);
        return (a == PMAX) ? a : a + 1'b1;
    endfunction

    // Each candidate keyword survives while its next character matches.
    always_comb begin
        for (int k = 0; k < NUM_KW; k++) begin
            kw_keep[k] = (r_ilen < KW_LEN[k]) && (r_ilen < 4'd8) &&
                         (KW_TEXT[k][r_ilen[2:0]] == c);
        end
        id_kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            if (r_cand[k] && (KW_LEN[k] == r_ilen)) begin
                id_kind = K_KEYWORD0 + 5'(k);
            end
        end
    end

    always_comb begin
        logic [LINE_BITS-1:0] ln;
        logic                 go_idle;
        logic [POS_BITS-1:0]  fe;
        c       = i_ch;
        is_dig  = (c >= "0") && (c <= "9");
        is_let  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        pos     = r_pos;
        pos1    = inc(r_pos);
        ts1     = inc(r_tstart);
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_line   = r_line;
        n_cand   = r_cand;
        n_ilen   = r_ilen;
        o_cnt    = '0;
        go_idle  = 1'b0;
        ln       = r_line;
        for (int i = 0; i < 4; i++) begin
            o_ctl[i]   = '0;
            o_start[i] = '0;
            o_len[i]   = '0;
            o_line[i]  = '0;
        end
        fe  = r_pos;
        pm1 = sub0(r_pos, POS_BITS'(1));

        if (i_char_valid) begin
            n_pos = pos1;
            fe    = pos1;
            case (r_mode)
                M_SLASH: begin
                    if (c == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        o_ctl[o_cnt[1:0]].kind = K_SLASH; o_start[o_cnt[1:0]] = r_tstart;
                        o_len[o_cnt[1:0]] = POS_BITS'(1); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        go_idle = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == 8'h0a) go_idle = 1'b1;
                end
                M_STRING: begin
                    if (c == "\"") begin
                        o_ctl[o_cnt[1:0]].kind = K_STRING; o_start[o_cnt[1:0]] = ts1;
                        o_len[o_cnt[1:0]] = sub0(pos, ts1); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h0a) begin
                        if (ln != LMAX) ln = ln + 1'b1;
                    end
                end
                M_NUMBER, M_FRACTION: begin
                    if (is_dig) begin
                    end else if (c == "." && r_mode == M_NUMBER) begin
                        n_mode = M_NUMDOT;
                    end else begin
                        o_ctl[o_cnt[1:0]].kind = K_NUMBER; o_start[o_cnt[1:0]] = r_tstart;
                        o_len[o_cnt[1:0]] = sub0(pos, r_tstart); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        go_idle = 1'b1;
                    end
                end
                M_NUMDOT: begin
                    if (is_dig) begin
                        n_mode = M_FRACTION;
                    end else begin
                        o_ctl[o_cnt[1:0]].kind = K_NUMBER; o_start[o_cnt[1:0]] = r_tstart;
                        o_len[o_cnt[1:0]] = sub0(pm1, r_tstart); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        o_ctl[o_cnt[1:0]].kind = K_DOT; o_start[o_cnt[1:0]] = pm1;
                        o_len[o_cnt[1:0]] = POS_BITS'(1); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        go_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_let || is_dig || c == "_") begin
                        n_cand = r_cand & kw_keep;
                        if (r_ilen != 4'd15) n_ilen = r_ilen + 4'd1;
                    end else begin
                        o_ctl[o_cnt[1:0]].kind = id_kind; o_start[o_cnt[1:0]] = r_tstart;
                        o_len[o_cnt[1:0]] = sub0(pos, r_tstart); o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                        go_idle = 1'b1;
                    end
                end
                default: go_idle = 1'b1;
            endcase

            if (go_idle) begin
                n_mode = M_IDLE;
                case (c)
                    "{", "}", ",", ".", ";": begin
                        o_ctl[o_cnt[1:0]].kind = (c == "{") ? K_LBRACE :
                                                 (c == "}") ? K_RBRACE :
                                                 (c == ",") ? K_COMMA :
                                                 (c == ".") ? K_DOT : K_SEMI;
                        o_start[o_cnt[1:0]] = pos; o_len[o_cnt[1:0]] = POS_BITS'(1);
                        o_line[o_cnt[1:0]] = ln;
                        o_cnt = o_cnt + 3'd1;
                    end
                    "/": begin
                        n_mode = M_SLASH; n_tstart = pos;
                    end
                    8'h0a: begin
                        if (ln != LMAX) ln = ln + 1'b1;
                    end
                    " ", 8'h0d, 8'h09: begin
                    end
                    "\"": begin
                        n_mode = M_STRING; n_tstart = pos;
                    end
                    default: begin
                        if (is_dig) begin
                            n_mode = M_NUMBER; n_tstart = pos;
                        end else if (is_let) begin
                            n_mode = M_IDENT; n_tstart = pos;
                            for (int k = 0; k < NUM_KW; k++) begin
                                n_cand[k] = (KW_TEXT[k][0] == c);
                            end
                            n_ilen = 4'd1;
                        end else begin
                            o_ctl[o_cnt[1:0]].kind = K_BAD;
                            o_ctl[o_cnt[1:0]].bad_char = c;
                            o_start[o_cnt[1:0]] = pos; o_len[o_cnt[1:0]] = POS_BITS'(1);
                            o_line[o_cnt[1:0]] = ln;
                            o_cnt = o_cnt + 3'd1;
                        end
                    end
                endcase
            end
        end

        if (i_eos) begin
            // Flush works on the state the byte above leaves behind.
            case (n_mode)
                M_SLASH: begin
                    o_ctl[o_cnt[1:0]].kind = K_SLASH; o_start[o_cnt[1:0]] = n_tstart;
                    o_len[o_cnt[1:0]] = POS_BITS'(1); o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                end
                M_STRING: begin
                    o_ctl[o_cnt[1:0]].kind = K_UNTERM;
                    o_start[o_cnt[1:0]] = inc(n_tstart);
                    o_len[o_cnt[1:0]] = sub0(fe, inc(n_tstart)); o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                end
                M_NUMBER, M_FRACTION: begin
                    o_ctl[o_cnt[1:0]].kind = K_NUMBER; o_start[o_cnt[1:0]] = n_tstart;
                    o_len[o_cnt[1:0]] = sub0(fe, n_tstart); o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                end
                M_NUMDOT: begin
                    o_ctl[o_cnt[1:0]].kind = K_NUMBER; o_start[o_cnt[1:0]] = n_tstart;
                    o_len[o_cnt[1:0]] = sub0(sub0(fe, POS_BITS'(1)), n_tstart);
                    o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                    o_ctl[o_cnt[1:0]].kind = K_DOT;
                    o_start[o_cnt[1:0]] = sub0(fe, POS_BITS'(1));
                    o_len[o_cnt[1:0]] = POS_BITS'(1); o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                end
                M_IDENT: begin
                    o_ctl[o_cnt[1:0]].kind = K_IDENT;
                    for (int k = 0; k < NUM_KW; k++) begin
                        if (n_cand[k] && (KW_LEN[k] == n_ilen)) begin
                            o_ctl[o_cnt[1:0]].kind = K_KEYWORD0 + 5'(k);
                        end
                    end
                    o_start[o_cnt[1:0]] = n_tstart;
                    o_len[o_cnt[1:0]] = sub0(fe, n_tstart); o_line[o_cnt[1:0]] = ln;
                    o_cnt = o_cnt + 3'd1;
                end
                default: begin
                end
            endcase
            o_ctl[o_cnt[1:0]].kind = K_END; o_start[o_cnt[1:0]] = fe;
            o_len[o_cnt[1:0]] = '0; o_line[o_cnt[1:0]] = ln;
            o_cnt = o_cnt + 3'd1;
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_tstart = '0;
            ln       = LINE_BITS'(r_first);
            n_cand   = '1;
            n_ilen   = '0;
        end
        n_line = ln;
        if (o_cnt != 3'd0) o_ctl[o_cnt[1:0] - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_line   <= LINE_BITS'(20'd1);
            r_first  <= 20'd1;
            r_cand   <= '1;
            r_ilen   <= '0;
        end else if (i_cfg_we) begin
            r_first <= i_cfg_data;
            r_line  <= LINE_BITS'(i_cfg_data);
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_line   <= n_line;
            r_cand   <= n_cand;
            r_ilen   <= n_ilen;
        end
    end

endmodule

// File: hw/rtl/kts_back.sv
`timescale 1ns / 1ps
module kts_back
    import kts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [2:0]           i_cnt,
    input  t_tok_ctl             i_ctl   [4],
    input  logic [POS_BITS-1:0]  i_start [4],
    input  logic [POS_BITS-1:0]  i_len   [4],
    input  logic [LINE_BITS-1:0] i_line  [4],
    output logic                 o_space,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [79:0]          o_tdata,
    output logic [4:0]           o_tuser,
    output logic                 o_tlast
);

    // Token queue with room for two worst-case items.
    localparam int DEPTH = 8;
    localparam int W = 5 + 8 + 1 + 2 * POS_BITS + LINE_BITS;

    logic [W-1:0] r_mem [DEPTH];
    logic [2:0]   r_wp, r_rp;
    logic [3:0]   r_used;
    logic         pop;
    logic [W-1:0] head;
    logic [23:0]  s_out, l_out;
    logic [19:0]  ln_out;

    assign head     = r_mem[r_rp];
    assign o_tvalid = (r_used != 4'd0);
    assign pop      = o_tvalid && i_tready;
    assign o_space  = (r_used <= 4'(DEPTH - 4)) || (pop && r_used == 4'(DEPTH - 3));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < i_cnt) begin
                    r_mem[r_wp + 3'(i)] <= {i_ctl[i], i_start[i], i_len[i], i_line[i]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_used <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + i_cnt;
            if (pop) r_rp <= r_rp + 3'd1;
            r_used <= r_used + (i_push ? {1'b0, i_cnt} : 4'd0) - {3'd0, pop};
        end
    end

    t_tok_ctl ctl;
    assign ctl    = head[W-1 -: 14];
    assign s_out  = head[2*POS_BITS+LINE_BITS-1 -: POS_BITS];
    assign l_out  = head[POS_BITS+LINE_BITS-1 -: POS_BITS];
    assign ln_out = head[LINE_BITS-1:0];
    assign o_tlast = ctl.last;
    assign o_tuser = ctl.kind;
    assign o_tdata = {4'b0, ctl.bad_char, ln_out, l_out, s_out};

endmodule

// File: hw/rtl/keyword_token_scanner_unit.sv
`timescale 1ns / 1ps
// Byte-serial lexical scanner. One source byte is taken per clock on the
// slave stream; each byte yields zero to four tokens, queued in an eight-entry
// token queue and drained one per clock on the master stream while it is
// ready. The front end accepts a new byte every cycle as long as the queue
// has room for four more tokens and no config write is pending, so
// sustained rate is one byte per cycle while the consumer keeps up; a byte
// that ends the source can produce up to four tokens. The token kind travels
// on tuser, and tlast marks the final token of each input request.
// Writing first_line (only while idle) also reloads the running line counter.
module keyword_token_scanner_unit
    import kts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic [1:0]  s_axis_tuser,   // char_valid, end_of_source
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // start, length, line, bad_char, pad
    output logic [4:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last_of_item
);

    logic                 take, space;
    logic [2:0]           cnt;
    t_tok_ctl             ctl   [4];
    logic [POS_BITS-1:0]  st    [4];
    logic [POS_BITS-1:0]  ln    [4];
    logic [LINE_BITS-1:0] lines [4];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = space && !i_cfg_valid;
    assign take          = s_axis_tvalid && s_axis_tready;

    kts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_take       (take),
        .i_ch         (s_axis_tdata),
        .i_char_valid (s_axis_tuser[0]),
        .i_eos        (s_axis_tuser[1]),
        .o_cnt        (cnt),
        .o_ctl        (ctl),
        .o_start      (st),
        .o_len        (ln),
        .o_line       (lines)
    );

    kts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take),
        .i_cnt    (cnt),
        .i_ctl    (ctl),
        .i_start  (st),
        .i_len    (ln),
        .i_line   (lines),
        .o_space  (space),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
